@@ hw/rtl/wma_pkg.sv @@
// ----------------------------------------------------------------------------
// wma_pkg
// Shared sizes, types and state codes for the windowed moving average.
// ----------------------------------------------------------------------------
package wma_pkg;

  // window and output scaling
  localparam int WINDOW    = 20;
  localparam int FRAC_BITS = 16;

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int MEAN_W   = 48;
  localparam int HELD_W   = 5;

  // derived widths
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int SUM_W      = SAMPLE_W + SLOT_W;
  localparam int DIVIDEND_W = SUM_W + FRAC_BITS;
  localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_OUT
  } state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hw/rtl/windowed_moving_average.sv @@
// ----------------------------------------------------------------------------
// windowed_moving_average
// Mean of the last WINDOW samples, as fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, sample) takes one 32-bit word. Output
//   channel (out_valid, out_stall, mean_fixed, samples_held) gives one word
//   per input word: floor(sum * 2^FRAC_BITS / count) and the count held.
//   Samples sit in a WINDOW-deep RAM; a running sum is updated by reading the
//   slot about to be overwritten, subtracting it once the window is full,
//   and adding the new sample.
//   An accepted word passes a RAM read, the update step, the bit-serial
//   divider (one quotient bit per cycle over the 53-bit scaled sum), and
//   the output state that loads the output register.
//   A new word is taken only after the previous one has left the divider
//   and the sequencer is back in idle.
//   in_stall is low only in idle; a word can be taken while the previous
//   result still waits in the output register.
//   Receiver stall: the output register holds its word; a finished result
//   then waits in the divider until the register frees up.
//   Reset: count, sum and slot pointer clear; the sample RAM is not cleared,
//   since an entry is only used after it has been written.
// ----------------------------------------------------------------------------
module windowed_moving_average (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wma_pkg::SAMPLE_W-1:0]  sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wma_pkg::MEAN_W-1:0]    mean_fixed,
  output logic [wma_pkg::HELD_W-1:0]    samples_held
);
  import wma_pkg::*;

  state_t state;
  state_t state_next;

  logic [SAMPLE_W-1:0]   sample_reg;
  logic [SUM_W-1:0]      running_sum;
  logic [SUM_W-1:0]      running_sum_next;
  logic [CNT_W-1:0]      fill_count;
  logic [CNT_W-1:0]      fill_count_next;
  logic [SLOT_W-1:0]     oldest_slot;
  logic [SLOT_W-1:0]     oldest_slot_next;
  logic [SAMPLE_W-1:0]   old_sample;
  logic                  full;
  logic                  in_accept;
  logic                  out_free;

  logic                  rd_en;
  logic                  wr_en;
  logic                  div_start;
  logic                  load_out;

  logic [DIVIDEND_W-1:0] quotient;
  div_stat_t             div_stat;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign full      = (fill_count == CNT_W'(WINDOW));

  // sample window storage
  wma_ram #(
    .DEPTH  (WINDOW),
    .DATA_W (SAMPLE_W),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (oldest_slot),
    .wdata (sample_reg),
    .re    (rd_en),
    .raddr (oldest_slot),
    .rdata (old_sample)
  );

  // serial divider
  wma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIVIDEND_W'(running_sum_next) << FRAC_BITS),
    .divisor  (fill_count_next),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DIV;
      ST_DIV:    if (div_stat.done) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_READ:   rd_en = 1'b1;
      ST_UPDATE: begin
        wr_en     = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV:    ;
      ST_OUT:    load_out = out_free;
      default:   ;
    endcase
  end

  // window bookkeeping for the update cycle
  always_comb begin
    running_sum_next = running_sum + SUM_W'(sample_reg)
                       - (full ? SUM_W'(old_sample) : SUM_W'(0));
    fill_count_next  = full ? fill_count : fill_count + CNT_W'(1);
    oldest_slot_next = (oldest_slot == SLOT_W'(WINDOW - 1)) ? '0
                                                            : oldest_slot + SLOT_W'(1);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running_sum <= '0;
      fill_count  <= '0;
      oldest_slot <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        running_sum <= running_sum_next;
        fill_count  <= fill_count_next;
        oldest_slot <= oldest_slot_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_reg <= sample;
    end
    if (load_out) begin
      mean_fixed   <= quotient[MEAN_W-1:0];
      samples_held <= HELD_W'(fill_count);
    end
  end

endmodule

@@ hw/rtl/wma_ram.sv @@
// ----------------------------------------------------------------------------
// wma_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wma_ram #(
  parameter int DEPTH  = 20,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/wma_div.sv @@
// ----------------------------------------------------------------------------
// wma_div
// Restoring bit-serial divider: scaled sum over the sample count, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module wma_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wma_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [wma_pkg::CNT_W-1:0]      divisor,
  output logic [wma_pkg::DIVIDEND_W-1:0] quotient,
  output wma_pkg::div_stat_t            stat
);
  import wma_pkg::*;

  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvsr;
  logic              done;
  logic [CNT_W:0]    trial;
  logic              q_bit;
  logic [CNT_W:0]    diff;

  // one trial subtraction
  always_comb begin
    trial = {rem, quotient[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvsr};
    q_bit = (trial >= {1'b0, dvsr});
  end

  // step counter and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= STEP_W'(DIVIDEND_W);
      done  <= 1'b0;
    end else begin
      done <= (steps == STEP_W'(1));
      if (steps != '0) begin
        steps <= steps - STEP_W'(1);
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (steps != '0) begin
      rem      <= q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], q_bit};
    end
  end

  assign stat.busy = (steps != '0);
  assign stat.done = done;

endmodule

@@ hw/rtl/wma_chk.sv @@
// ----------------------------------------------------------------------------
// wma_chk
// Port-level checks for the windowed moving average, bound to the top level.
// ----------------------------------------------------------------------------
module wma_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [wma_pkg::SAMPLE_W-1:0]  sample,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [wma_pkg::MEAN_W-1:0]    mean_fixed,
  input logic [wma_pkg::HELD_W-1:0]    samples_held
);
  import wma_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean_fixed) && $stable(samples_held))
    else $error("output word changed while stalled");

  // held count always within the window
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (samples_held != '0) && (samples_held <= HELD_W'(WINDOW)))
    else $error("samples_held out of range");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !$isunknown(in_stall))
    else $error("output valid after reset");

  // one word at a time: the input closes after each accepted word
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in work");

endmodule

bind windowed_moving_average wma_chk u_wma_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .sample       (sample),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .mean_fixed   (mean_fixed),
  .samples_held (samples_held)
);
